// ===== hw/rtl/stdec_pkg.sv =====
// shared types, codes and constants of the streaming text decoder
package stdec_pkg;

   // encoding machine select
   typedef enum logic [1:0] {
      ENC_UTF8    = 2'd0,
      ENC_UTF16LE = 2'd1,
      ENC_UTF16BE = 2'd2,
      ENC_USER    = 2'd3
   } encoding_type;

   // configuration register indexes
   localparam logic [1:0] CSR_ENCODING = 2'd0;
   localparam logic [1:0] CSR_FATAL    = 2'd1;
   localparam logic [1:0] CSR_KEEP_BOM = 2'd2;

   // code points with a special role
   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] CP_BOM         = 21'h00FEFF;
   localparam logic [20:0] CP_SUPPLEMENT  = 21'h010000;
   localparam logic [20:0] CP_USER_BASE   = 21'h00F700;

   // utf-8 continuation byte window
   localparam logic [7:0] CONT_LOW  = 8'h80;
   localparam logic [7:0] CONT_HIGH = 8'hBF;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // configuration as seen by the decode logic
   typedef struct packed {
      encoding_type mode;
      logic         fatal;
      logic         keep_bom;
   } cfg_type;

   // decoder state carried from one request to the next
   typedef struct packed {
      logic [20:0] partial;
      logic [1:0]  needed;
      logic [1:0]  seen;
      logic [7:0]  lower;
      logic [7:0]  upper;
      logic        held_valid;
      logic [7:0]  held;
      logic        lead_valid;
      logic [9:0]  lead;
      logic        first_seen;
   } dec_state_type;

   localparam dec_state_type STATE_RESET = '{
      partial:    21'd0,
      needed:     2'd0,
      seen:       2'd0,
      lower:      CONT_LOW,
      upper:      CONT_HIGH,
      held_valid: 1'b0,
      held:       8'd0,
      lead_valid: 1'b0,
      lead:       10'd0,
      first_seen: 1'b0
   };

   // one result item
   typedef struct packed {
      logic [20:0] code_point;
      logic        is_error;
      logic        is_last;
   } result_type;

endpackage

// ===== hw/rtl/streaming_text_decoder_core.sv =====
// top level of the streaming text decoder: input register, decode step, result queue
// the first result of a request is offered once the input register has held it and the
//   decode step has written its results into the queue; a queue without room stalls the step
// throughput: one request per cycle while each yields at most one result and the queue has
//   room for two; a request with two results takes longer on the result port, which moves one a cycle
// a four-entry result queue takes both results of a step at once and parts the two sides
// reset (synchronous, active high) clears config, decoder state and the queue
module streaming_text_decoder_core
   import stdec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_is_error,
   output logic        rsp_is_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_write_data
);

   cfg_type               cfg_ff;
   logic                  in_valid_ff;
   logic                  in_cmd_ff;
   logic [7:0]            in_byte_ff;
   dec_state_type         state_ff;
   dec_state_type         state_in;
   result_type            res0;
   result_type            res1;
   logic [1:0]            res_count;
   logic                  step_fire;
   logic                  pop;
   logic [1:0]            push_count;
   result_type            queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_next;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QCOUNT_W-1:0]   count_ff;
   logic [QCOUNT_W-1:0]   count_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: ENC_UTF8, fatal: 1'b0, keep_bom: 1'b0};
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENCODING: cfg_ff.mode     <= encoding_type'(csr_write_data);
            CSR_FATAL:    cfg_ff.fatal    <= csr_write_data[0];
            CSR_KEEP_BOM: cfg_ff.keep_bom <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // decode step runs when the queue has room for two results
   assign step_fire = in_valid_ff && (count_ff <= QCOUNT_W'(QUEUE_DEPTH - 2));
   assign req_ready = !in_valid_ff || step_fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_byte_value;
      end
   end

   stdec_decode u_decode (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .cmd        (in_cmd_ff),
      .byte_value (in_byte_ff),
      .next_state (state_in),
      .res0       (res0),
      .res1       (res1),
      .res_count  (res_count)
   );

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // result queue
   assign push_count  = step_fire ? res_count : 2'd0;
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + QUEUE_AW'(1);
   assign count_in    = count_ff + QCOUNT_W'(push_count) - QCOUNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) queue_ff[wr_ptr_ff] <= res0;
      if (push_count == 2'd2) queue_ff[wr_ptr_next] <= res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(push_count);
         rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(pop);
         count_ff  <= count_in;
      end
   end

   // result port
   assign rsp_valid      = (count_ff != '0);
   assign rsp_code_point = queue_ff[rd_ptr_ff].code_point;
   assign rsp_is_error   = queue_ff[rd_ptr_ff].is_error;
   assign rsp_is_last    = queue_ff[rd_ptr_ff].is_last;

endmodule

// ===== hw/rtl/stdec_decode.sv =====
// single-step decode: one request and the current state give up to two results
module stdec_decode
   import stdec_pkg::*;
(
   input  cfg_type       cfg,
   input  dec_state_type state,
   input  logic          cmd,
   input  logic [7:0]    byte_value,
   output dec_state_type next_state,
   output result_type    res0,
   output result_type    res1,
   output logic [1:0]    res_count
);

   // classification of a utf-8 byte seen with no sequence open
   typedef struct packed {
      logic        bad;
      logic        ascii;
      logic [1:0]  needed;
      logic [20:0] partial;
      logic [7:0]  lower;
      logic [7:0]  upper;
   } lead_type;

   function automatic lead_type utf8_lead(input logic [7:0] b);
      lead_type l;
      l = '{default: '0};
      l.lower = CONT_LOW;
      l.upper = CONT_HIGH;
      if (b <= 8'h7F) begin
         l.ascii = 1'b1;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         l.needed  = 2'd1;
         l.partial = {16'd0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         l.needed  = 2'd2;
         l.partial = {17'd0, b[3:0]};
         if (b == 8'hE0) l.lower = 8'hA0;
         if (b == 8'hED) l.upper = 8'h9F;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         l.needed  = 2'd3;
         l.partial = {18'd0, b[2:0]};
         if (b == 8'hF0) l.lower = 8'h90;
         if (b == 8'hF4) l.upper = 8'h8F;
      end else begin
         l.bad = 1'b1;
      end
      return l;
   endfunction

   lead_type      lead_info;
   logic [15:0]   unit;
   logic          unit_high;
   logic          unit_low;
   logic [20:0]   partial_shift;
   logic [1:0]    seen_inc;
   dec_state_type ns;
   logic          c0_valid;
   logic          c1_valid;
   logic [20:0]   c0;
   logic [20:0]   c1;
   logic          fail;
   logic          keep0;
   logic          keep1;
   logic          first;

   assign lead_info     = utf8_lead(byte_value);
   assign unit          = (cfg.mode == ENC_UTF16BE) ? {state.held, byte_value}
                                                    : {byte_value, state.held};
   assign unit_high     = (unit[15:10] == 6'b110110);
   assign unit_low      = (unit[15:10] == 6'b110111);
   assign partial_shift = {state.partial[14:0], byte_value[5:0]};
   assign seen_inc      = state.seen + 2'd1;

   // candidate results and state update per machine
   always_comb begin
      ns       = state;
      c0_valid = 1'b0;
      c1_valid = 1'b0;
      c0       = '0;
      c1       = '0;
      fail     = 1'b0;
      if (cmd) begin
         // flush: anything still open becomes one replacement or an error
         if (state.needed != 2'd0 || state.held_valid || state.lead_valid) begin
            if (cfg.fatal) begin
               fail = 1'b1;
            end else begin
               c0_valid = 1'b1;
               c0       = CP_REPLACEMENT;
            end
         end
      end else begin
         unique case (cfg.mode) inside
            ENC_UTF8: begin
               if (state.needed == 2'd0) begin
                  // no sequence open
                  if (lead_info.ascii) begin
                     c0_valid = 1'b1;
                     c0       = {13'd0, byte_value};
                  end else if (lead_info.bad) begin
                     if (cfg.fatal) begin
                        fail = 1'b1;
                     end else begin
                        c0_valid = 1'b1;
                        c0       = CP_REPLACEMENT;
                     end
                  end else begin
                     ns.needed  = lead_info.needed;
                     ns.partial = lead_info.partial;
                     ns.lower   = lead_info.lower;
                     ns.upper   = lead_info.upper;
                  end
               end else if (byte_value < state.lower || byte_value > state.upper) begin
                  // broken sequence: replace, then take the byte as a fresh lead
                  ns.partial = '0;
                  ns.needed  = 2'd0;
                  ns.seen    = 2'd0;
                  ns.lower   = CONT_LOW;
                  ns.upper   = CONT_HIGH;
                  if (cfg.fatal) begin
                     fail = 1'b1;
                  end else begin
                     c0_valid = 1'b1;
                     c0       = CP_REPLACEMENT;
                     if (lead_info.ascii) begin
                        c1_valid = 1'b1;
                        c1       = {13'd0, byte_value};
                     end else if (lead_info.bad) begin
                        c1_valid = 1'b1;
                        c1       = CP_REPLACEMENT;
                     end else begin
                        ns.needed  = lead_info.needed;
                        ns.partial = lead_info.partial;
                        ns.lower   = lead_info.lower;
                        ns.upper   = lead_info.upper;
                     end
                  end
               end else begin
                  // good continuation byte
                  ns.lower = CONT_LOW;
                  ns.upper = CONT_HIGH;
                  if (seen_inc == state.needed) begin
                     c0_valid   = 1'b1;
                     c0         = partial_shift;
                     ns.partial = '0;
                     ns.needed  = 2'd0;
                     ns.seen    = 2'd0;
                  end else begin
                     ns.partial = partial_shift;
                     ns.seen    = seen_inc;
                  end
               end
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
               if (!state.held_valid) begin
                  ns.held_valid = 1'b1;
                  ns.held       = byte_value;
               end else begin
                  ns.held_valid = 1'b0;
                  ns.held       = '0;
                  if (state.lead_valid) begin
                     ns.lead_valid = 1'b0;
                     ns.lead       = '0;
                     if (unit_low) begin
                        // surrogate pair joins
                        c0_valid = 1'b1;
                        c0       = CP_SUPPLEMENT + {1'b0, state.lead, unit[9:0]};
                     end else if (cfg.fatal) begin
                        fail = 1'b1;
                     end else begin
                        // lead without trail, then the unit as a fresh one
                        c0_valid = 1'b1;
                        c0       = CP_REPLACEMENT;
                        if (unit_high) begin
                           ns.lead_valid = 1'b1;
                           ns.lead       = unit[9:0];
                        end else begin
                           c1_valid = 1'b1;
                           c1       = {5'd0, unit};
                        end
                     end
                  end else if (unit_high) begin
                     ns.lead_valid = 1'b1;
                     ns.lead       = unit[9:0];
                  end else if (unit_low) begin
                     // lone trail
                     if (cfg.fatal) begin
                        fail = 1'b1;
                     end else begin
                        c0_valid = 1'b1;
                        c0       = CP_REPLACEMENT;
                     end
                  end else begin
                     c0_valid = 1'b1;
                     c0       = {5'd0, unit};
                  end
               end
            end
            ENC_USER: begin
               c0_valid = 1'b1;
               c0       = byte_value[7] ? (CP_USER_BASE + {13'd0, byte_value})
                                        : {13'd0, byte_value};
            end
            default: begin
            end
         endcase
      end
   end

   // leading mark filter, error override and result packing
   always_comb begin
      first      = state.first_seen;
      keep0      = c0_valid;
      keep1      = c1_valid;
      next_state = ns;
      res0       = '0;
      res1       = '0;
      res_count  = 2'd0;
      if (c0_valid && !cfg.keep_bom && !first) begin
         first = 1'b1;
         if (c0 == CP_BOM) keep0 = 1'b0;
      end
      if (c1_valid && !cfg.keep_bom && !first) begin
         first = 1'b1;
         if (c1 == CP_BOM) keep1 = 1'b0;
      end
      next_state.first_seen = first;
      if (fail) begin
         next_state = STATE_RESET;
         res0       = '{code_point: 21'd0, is_error: 1'b1, is_last: 1'b1};
         res_count  = 2'd1;
      end else begin
         if (cmd) next_state = STATE_RESET;
         if (keep0 && keep1) begin
            res0      = '{code_point: c0, is_error: 1'b0, is_last: 1'b0};
            res1      = '{code_point: c1, is_error: 1'b0, is_last: 1'b1};
            res_count = 2'd2;
         end else if (keep0) begin
            res0      = '{code_point: c0, is_error: 1'b0, is_last: 1'b1};
            res_count = 2'd1;
         end else if (keep1) begin
            res0      = '{code_point: c1, is_error: 1'b0, is_last: 1'b1};
            res_count = 2'd1;
         end
      end
   end

endmodule

// ===== hw/rtl/stdec_checker.sv =====
// port-level checks of the streaming text decoder and their bind
module stdec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] rsp_code_point,
   input logic        rsp_is_error,
   input logic        rsp_is_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable({rsp_code_point, rsp_is_error, rsp_is_last}))
      else $error("stalled result changed");

   // an error result stands alone with a zero code point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_error |-> rsp_code_point == 21'd0 && rsp_is_last)
      else $error("malformed error result");

   // decoded values are scalar values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_error |->
         rsp_code_point <= 21'h10FFFF &&
         !(rsp_code_point >= 21'h00D800 && rsp_code_point <= 21'h00DFFF))
      else $error("result is not a scalar value");

   // reset empties the result queue
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind streaming_text_decoder_core stdec_checker u_stdec_checker (.*);
